// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define HCBP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// clocked assertion that also holds through reset
`define HCBP_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/hcbp_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbp_pkg
// types and constants of the huffman code bit packer
// ----------------------------------------------------------------------------
package hcbp_pkg;

   localparam int CODE_W       = 32;
   localparam int LEN_W        = 6;
   localparam int SYM_W        = 9;
   localparam int OP_W         = 2;
   localparam int BYTE_W       = 8;
   localparam int TABLE_DEPTH  = 257;
   localparam int MAX_CODE_LEN = 32;
   localparam int LEN_LIMIT    = (MAX_CODE_LEN > CODE_W) ? CODE_W : MAX_CODE_LEN;
   localparam int PEND_W       = BYTE_W - 1;
   localparam int ACC_W        = CODE_W + PEND_W;
   localparam int CNT_W        = $clog2(ACC_W + 1);
   localparam int ENTRY_W      = CODE_W + LEN_W;

   localparam logic [SYM_W-1:0] END_MARKER = SYM_W'(TABLE_DEPTH - 1);

   localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
   localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
   localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [SYM_W-1:0]  symbol;
      logic [CODE_W-1:0] code_value;
      logic [LEN_W-1:0]  code_length;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              last_of_run;
      logic              stream_end;
   } rsp_type;

   typedef struct packed {
      logic [LEN_W-1:0]  len;
      logic [CODE_W-1:0] code;
   } entry_type;

endpackage

// ===== sv/huffman_code_bit_packer_unit.sv =====
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_unit
// huffman encoder: code table in ram, bit accumulator, byte output
// ----------------------------------------------------------------------------
// After reset the block sweeps its 257-entry code table to zero length, one
// entry a cycle, and holds req_stall high until the sweep is done. A load item
// is one table write. An encode or finish item reads its table entry
// through the ram and then stays in the packer while it emits its bytes (up
// to five), one byte per cycle while rsp_stall does not hold the output; the
// packer picks up the next item in the cycle its last byte leaves, so it
// takes each new item without first idling.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hcbp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hcbp_pkg::rsp_type rsp_data
);

   // table clear sweep
   logic                          clr_busy_ff, clr_busy_in;
   logic [hcbp_pkg::SYM_W-1:0]    clr_addr_ff, clr_addr_in;

   // request decode
   logic                          req_take;
   logic                          sym_ok;
   logic                          is_load;
   logic                          is_read;
   logic [hcbp_pkg::SYM_W-1:0]    rd_addr;
   logic [hcbp_pkg::LEN_W-1:0]    len_sat;
   logic [hcbp_pkg::CODE_W-1:0]   code_mask;
   hcbp_pkg::entry_type           load_entry;

   // ram ports
   logic                          wr_en;
   logic [hcbp_pkg::SYM_W-1:0]    wr_addr;
   hcbp_pkg::entry_type           wr_data;
   logic                          rd_en;
   hcbp_pkg::entry_type           rd_data;

   // read stage and buffer
   logic                          s1_vld_ff, s1_vld_in;
   logic                          s1_fin_ff, s1_fin_in;
   logic                          s1_move;
   logic                          buf_vld_ff, buf_vld_in;
   logic                          buf_fin_ff, buf_fin_in;
   hcbp_pkg::entry_type           buf_entry_ff, buf_entry_in;
   logic                          buf_take;

   // packer
   logic [hcbp_pkg::ACC_W-1:0]    acc_ff, acc_in, acc_s;
   logic [hcbp_pkg::CNT_W-1:0]    cnt_ff, cnt_in, cnt_s, rem, tot;
   logic                          fin_ff, fin_in;
   logic                          act_ff, act_in, act_s;
   logic [3:0]                    pad_sh;
   logic                          last;
   logic                          emit;
   hcbp_pkg::rsp_type             emit_data;
   logic                          out_free;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   hcbp_pkg::rsp_type             rsp_data_ff, rsp_data_in;

   // request side
   assign req_take = req_valid && !req_stall;
   assign sym_ok   = req_data.symbol < hcbp_pkg::SYM_W'(hcbp_pkg::TABLE_DEPTH);
   assign is_load  = (req_data.operation == hcbp_pkg::OP_LOAD) && sym_ok;
   assign is_read  = ((req_data.operation == hcbp_pkg::OP_ENCODE) && sym_ok)
                     || (req_data.operation == hcbp_pkg::OP_FINISH);
   assign rd_addr  = (req_data.operation == hcbp_pkg::OP_FINISH) ?
                     hcbp_pkg::END_MARKER : req_data.symbol;

   assign s1_move   = s1_vld_ff && (!buf_vld_ff || buf_take);
   assign req_stall = clr_busy_ff || (s1_vld_ff && !s1_move);
   assign rd_en     = req_take && is_read;

   always_comb begin
      if (req_data.code_length > hcbp_pkg::LEN_W'(hcbp_pkg::LEN_LIMIT)) begin
         len_sat = hcbp_pkg::LEN_W'(hcbp_pkg::LEN_LIMIT);
      end else begin
         len_sat = req_data.code_length;
      end
      code_mask       = ~({hcbp_pkg::CODE_W{1'b1}} << len_sat);
      load_entry.len  = len_sat;
      load_entry.code = req_data.code_value & code_mask;
   end

   always_comb begin
      if (clr_busy_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = req_take && is_load;
         wr_addr = req_data.symbol;
         wr_data = load_entry;
      end
   end

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + hcbp_pkg::SYM_W'(1);
         if (clr_addr_ff == hcbp_pkg::END_MARKER) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   hcbp_ram #(
      .WIDTH (hcbp_pkg::ENTRY_W),
      .DEPTH (hcbp_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // read stage and buffer
   always_comb begin
      s1_vld_in    = s1_vld_ff;
      s1_fin_in    = s1_fin_ff;
      buf_vld_in   = buf_vld_ff;
      buf_fin_in   = buf_fin_ff;
      buf_entry_in = buf_entry_ff;
      if (s1_move) begin
         s1_vld_in = 1'b0;
      end
      if (rd_en) begin
         s1_vld_in = 1'b1;
         s1_fin_in = (req_data.operation == hcbp_pkg::OP_FINISH);
      end
      if (buf_take) begin
         buf_vld_in = 1'b0;
      end
      if (s1_move) begin
         buf_vld_in   = 1'b1;
         buf_fin_in   = s1_fin_ff;
         buf_entry_in = rd_data;
      end
   end

   // packer: one byte per cycle while the output is not stalled, then take the next entry
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      acc_s     = acc_ff;
      cnt_s     = cnt_ff;
      act_s     = act_ff;
      emit      = 1'b0;
      emit_data = '0;
      last      = 1'b0;
      rem       = cnt_ff - hcbp_pkg::CNT_W'(hcbp_pkg::BYTE_W);
      pad_sh    = 4'(hcbp_pkg::BYTE_W) - {1'b0, cnt_ff[2:0]};
      if (act_ff && out_free) begin
         emit = 1'b1;
         if (cnt_ff >= hcbp_pkg::CNT_W'(hcbp_pkg::BYTE_W)) begin
            emit_data.out_byte = hcbp_pkg::BYTE_W'(acc_ff >> rem);
            cnt_s              = rem;
            last = fin_ff ? (rem == '0) : (rem < hcbp_pkg::CNT_W'(hcbp_pkg::BYTE_W));
         end else begin
            emit_data.out_byte = acc_ff[hcbp_pkg::BYTE_W-1:0] << pad_sh;
            cnt_s              = '0;
            last               = 1'b1;
         end
         emit_data.last_of_run = last;
         emit_data.stream_end  = fin_ff && last;
         act_s = (cnt_s >= hcbp_pkg::CNT_W'(hcbp_pkg::BYTE_W)) || (fin_ff && (cnt_s != '0));
      end
   end

   assign buf_take = buf_vld_ff && !act_s;

   always_comb begin
      acc_in = acc_s;
      cnt_in = cnt_s;
      act_in = act_s;
      fin_in = fin_ff;
      tot    = cnt_s + hcbp_pkg::CNT_W'(buf_entry_ff.len);
      if (buf_take) begin
         acc_in = (acc_s << buf_entry_ff.len) | hcbp_pkg::ACC_W'(buf_entry_ff.code);
         cnt_in = tot;
         fin_in = buf_fin_ff;
         act_in = (tot >= hcbp_pkg::CNT_W'(hcbp_pkg::BYTE_W)) || (buf_fin_ff && (tot != '0));
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_vld_ff    <= 1'b0;
         buf_vld_ff   <= 1'b0;
         cnt_ff       <= '0;
         act_ff       <= 1'b0;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_busy_ff  <= clr_busy_in;
         clr_addr_ff  <= clr_addr_in;
         s1_vld_ff    <= s1_vld_in;
         buf_vld_ff   <= buf_vld_in;
         cnt_ff       <= cnt_in;
         act_ff       <= act_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_fin_ff    <= s1_fin_in;
      buf_fin_ff   <= buf_fin_in;
      buf_entry_ff <= buf_entry_in;
      acc_ff       <= acc_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

// ===== sv/hcbp_ram.sv =====
// ----------------------------------------------------------------------------
// hcbp_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module hcbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/hcbp_checker.sv =====
// ----------------------------------------------------------------------------
// hcbp_checker
// port level checks of the huffman code bit packer
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hcbp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input hcbp_pkg::rsp_type rsp_data
);

   `HCBP_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled item changed")
   `HCBP_ASSERT(a_end_is_last, clock, reset, rsp_valid && rsp_data.stream_end |-> rsp_data.last_of_run, "stream end without last of run")
   `HCBP_ASSERT_NR(a_reset_quiet, clock, reset |=> req_stall && !rsp_valid, "block not quiet after reset")

endmodule

bind huffman_code_bit_packer_unit hcbp_checker u_hcbp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
